FILE: sv/ppf_pkg.sv
// Shared constants and controller/datapath interface types for the prime power factorizer.
package ppf_pkg;

    localparam int VALUE_BITS   = 16;
    localparam int FIELD_W      = 16;
    localparam int VAL_W        = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
    localparam int SQ_W         = 2 * VAL_W;
    localparam int STEP_W       = (VAL_W > 1) ? $clog2(VAL_W) : 1;
    localparam int RESULT_LIMIT = 6;
    localparam int COUNT_W      = $clog2(RESULT_LIMIT);

    typedef struct packed {
        logic load;
        logic emit_empty;
        logic emit_rem;
        logic emit_fold;
        logic emit_last;
        logic emit_mid;
        logic div_start;
        logic div_step;
        logic factor;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic le_one;
        logic sq_gt;
        logic div_done;
        logic rem_zero;
        logic found;
        logic at_limit;
        logic rem_gt1;
        logic rem_one;
    } t_status;

endpackage

FILE: sv/prime_power_factorizer_top.sv
// Top level of the prime power factorizer: controller and datapath.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  request  | start, busy (start & !busy) | i_value[15:0]
//  result   | o_valid, one-cycle strobe  | o_prime_power[15:0], o_last, o_empty_res
//
// Inputs 0 and 1 answer in the cycle after the request, busy stays low.
// Otherwise each trial divisor goes through a square check and a
// one-bit-per-cycle restoring divider, and each extra division by a found
// prime runs the divider again.
// Synchronous active-low reset returns the controller to idle.
// The receiver cannot stall; busy drops in the cycle the last result is shown.
module prime_power_factorizer_top
    import ppf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FIELD_W-1:0] i_value,
    output logic               o_valid,
    output logic [FIELD_W-1:0] o_prime_power,
    output logic               o_last,
    output logic               o_empty_res
);

    t_cmd    cmd;
    t_status status;

    ppf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start & ~busy),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    ppf_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_prime_power (o_prime_power),
        .o_last        (o_last),
        .o_empty_res   (o_empty_res)
    );

endmodule

FILE: sv/ppf_datapath.sv
// Datapath: quotient, trial divisor, power register, serial divider and result register.
module ppf_datapath
    import ppf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [FIELD_W-1:0] i_value,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic               o_valid,
    output logic [FIELD_W-1:0] o_prime_power,
    output logic               o_last,
    output logic               o_empty_res
);

    logic [VAL_W-1:0]   r_rem;
    logic [VAL_W-1:0]   r_div;
    logic [VAL_W-1:0]   r_pacc;
    logic [SQ_W-1:0]    r_sq;
    logic               r_found;
    logic [COUNT_W-1:0] r_count;
    logic [VAL_W-1:0]   r_div_q;
    logic [VAL_W-1:0]   r_div_r;
    logic [STEP_W-1:0]  r_step;
    logic               r_valid;
    logic [FIELD_W-1:0] r_pp;
    logic               r_last;
    logic               r_empty;

    logic [VAL_W-1:0]   in_val;
    logic [VAL_W:0]     div_trial;
    logic               div_fits;
    logic [VAL_W-1:0]   n_div_r;
    logic [VAL_W-1:0]   n_div_q;
    logic [SQ_W-1:0]    pacc_mul_d;
    logic [SQ_W-1:0]    pacc_mul_rem;

    assign in_val       = i_value[VAL_W-1:0];
    assign div_trial    = {r_div_r, r_div_q[VAL_W-1]};
    assign div_fits     = div_trial >= {1'b0, r_div};
    assign n_div_r      = div_fits ? VAL_W'(div_trial - {1'b0, r_div}) : div_trial[VAL_W-1:0];
    assign n_div_q      = {r_div_q[VAL_W-2:0], div_fits};
    assign pacc_mul_d   = r_pacc * r_div;
    assign pacc_mul_rem = r_pacc * r_rem;

    always_comb begin
        o_status          = '0;
        o_status.le_one   = in_val <= VAL_W'(1);
        o_status.sq_gt    = r_sq > {{VAL_W{1'b0}}, r_rem};
        o_status.div_done = r_step == STEP_W'(VAL_W - 1);
        o_status.rem_zero = n_div_r == '0;
        o_status.found    = r_found;
        o_status.at_limit = r_count == COUNT_W'(RESULT_LIMIT - 1);
        o_status.rem_gt1  = r_rem > VAL_W'(1);
        o_status.rem_one  = r_rem == VAL_W'(1);
    end

    always_ff @(posedge i_clk) begin
        r_sq <= r_div * r_div;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_count <= '0;
            r_rem   <= '0;
            r_div   <= '0;
            r_pacc  <= '0;
        end else begin
            r_valid <= i_cmd.emit_empty | i_cmd.emit_rem | i_cmd.emit_fold
                     | i_cmd.emit_last | i_cmd.emit_mid;
            if (i_cmd.load) begin
                r_rem   <= in_val;
                r_div   <= VAL_W'(2);
                r_pacc  <= VAL_W'(1);
                r_found <= 1'b0;
                r_count <= '0;
            end
            if (i_cmd.div_start) begin
                r_div_q <= r_rem;
                r_div_r <= '0;
                r_step  <= '0;
            end
            if (i_cmd.div_step) begin
                r_div_q <= n_div_q;
                r_div_r <= n_div_r;
                r_step  <= r_step + STEP_W'(1);
            end
            if (i_cmd.factor) begin
                r_rem   <= n_div_q;
                r_pacc  <= pacc_mul_d[VAL_W-1:0];
                r_found <= 1'b1;
                r_div_q <= n_div_q;
                r_div_r <= '0;
                r_step  <= '0;
            end
            if (i_cmd.advance) begin
                r_div   <= (r_div == VAL_W'(2)) ? VAL_W'(3) : r_div + VAL_W'(2);
                r_pacc  <= VAL_W'(1);
                r_found <= 1'b0;
            end
            if (i_cmd.emit_empty) begin
                r_pp    <= '0;
                r_last  <= 1'b1;
                r_empty <= 1'b1;
            end
            if (i_cmd.emit_rem) begin
                r_pp    <= FIELD_W'(r_rem);
                r_last  <= 1'b1;
                r_empty <= 1'b0;
            end
            if (i_cmd.emit_fold) begin
                r_pp    <= FIELD_W'(pacc_mul_rem[VAL_W-1:0]);
                r_last  <= 1'b1;
                r_empty <= 1'b0;
            end
            if (i_cmd.emit_last) begin
                r_pp    <= FIELD_W'(r_pacc);
                r_last  <= 1'b1;
                r_empty <= 1'b0;
            end
            if (i_cmd.emit_mid) begin
                r_pp    <= FIELD_W'(r_pacc);
                r_last  <= 1'b0;
                r_empty <= 1'b0;
                r_count <= r_count + COUNT_W'(1);
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_prime_power = r_pp;
    assign o_last        = r_last;
    assign o_empty_res   = r_empty;

`ifndef ASSERT_OFF
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_empty |-> r_last && (r_pp == '0))
        else $error("empty result without last or with nonzero power");
    a_power_gt1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_empty |-> r_pp > FIELD_W'(1))
        else $error("nonempty result carries power below two");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(RESULT_LIMIT - 1))
        else $error("result count past limit");
    a_factor_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.factor |-> o_status.rem_zero && o_status.div_done)
        else $error("quotient taken from inexact division");
`endif

endmodule

FILE: sv/ppf_ctrl.sv
// Controller: sequences load, divisor square check, serial division and result emission.
module ppf_ctrl
    import ppf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_CHECK,
        S_DIV,
        S_RESOLVE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_busy  = r_busy;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_status.le_one) begin
                        o_cmd.emit_empty = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SQ;
                        n_busy     = 1'b1;
                    end
                end
            end
            S_SQ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.sq_gt) begin
                    o_cmd.emit_rem = 1'b1;
                    n_state        = S_IDLE;
                    n_busy         = 1'b0;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_RESOLVE;
                    if (i_status.rem_zero) begin
                        o_cmd.factor = 1'b1;
                        n_state      = S_DIV;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_RESOLVE: begin
                if (i_status.found && i_status.at_limit && i_status.rem_gt1) begin
                    o_cmd.emit_fold = 1'b1;
                    n_state         = S_IDLE;
                    n_busy          = 1'b0;
                end else if (i_status.found && i_status.rem_one) begin
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                    n_busy          = 1'b0;
                end else begin
                    o_cmd.emit_mid = i_status.found;
                    o_cmd.advance  = 1'b1;
                    n_state        = S_SQ;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

FILE: dv/prime_power_factorizer_top_tb.sv
// Self-checking testbench for the prime power factorizer: directed and random requests.
`timescale 1ns / 100ps

module prime_power_factorizer_top_tb
    import ppf_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2600;
    localparam int PRINT_LIMIT    = 200;

    typedef struct {
        logic [FIELD_W-1:0] source;
        logic [FIELD_W-1:0] prime_power;
        logic               last;
        logic               empty_res;
    } t_factor;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [FIELD_W-1:0] i_value;
    logic               o_valid;
    logic [FIELD_W-1:0] o_prime_power;
    logic               o_last;
    logic               o_empty_res;

    t_factor expected_factors[$];
    t_factor want;
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;

    prime_power_factorizer_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_prime_power(o_prime_power),
        .o_last       (o_last),
        .o_empty_res  (o_empty_res)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    function automatic void push_power(input logic [FIELD_W-1:0] source, input int unsigned pp,
                                       input logic last, input logic empty_res);
        t_factor f;
        f.source      = source;
        f.prime_power = FIELD_W'(pp);
        f.last        = last;
        f.empty_res   = empty_res;
        expected_factors.insert(expected_factors.size(), f);
    endfunction

    // Trial division: 2, then odd divisors while d*d <= quotient; leftover quotient is prime.
    function automatic void queue_prime_powers(input logic [FIELD_W-1:0] value);
        longint unsigned quotient;
        longint unsigned divisor;
        longint unsigned power;
        int              count;
        quotient = longint'(value) & ((64'd1 << VAL_W) - 1);
        count    = 0;
        if (quotient <= 1) begin
            push_power(value, 0, 1'b1, 1'b1);
            return;
        end
        divisor = 2;
        while (divisor * divisor <= quotient) begin
            if (quotient % divisor == 0) begin
                power = 1;
                while (quotient % divisor == 0) begin
                    quotient = quotient / divisor;
                    power    = power * divisor;
                end
                if (count == RESULT_LIMIT - 1 && quotient > 1) begin
                    push_power(value, int'(power * quotient), 1'b1, 1'b0);
                    return;
                end
                if (quotient == 1) begin
                    push_power(value, int'(power), 1'b1, 1'b0);
                    return;
                end
                push_power(value, int'(power), 1'b0, 1'b0);
                count++;
            end
            divisor = (divisor == 2) ? 3 : divisor + 2;
        end
        push_power(value, int'(quotient), 1'b1, 1'b0);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_value();
        int unsigned product;
        int unsigned factor;
        case ($urandom_range(0, 9)) inside
            0: return FIELD_W'($urandom_range(0, 1));
            [1:3]: return FIELD_W'($urandom);
            [4:5]: return FIELD_W'($urandom & ((32'd1 << $urandom_range(2, 16)) - 1));
            default: begin
                // smooth numbers: many small factors, several results per request
                product = 1;
                forever begin
                    factor = $urandom_range(2, 40);
                    if (product * factor > 65535) break;
                    product = product * factor;
                end
                return FIELD_W'(product);
            end
        endcase
    endfunction

    task automatic send_request(input logic [FIELD_W-1:0] value, input int idle_pct);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < idle_pct / 4) begin
            start   <= 1'b0;
            i_value <= FIELD_W'($urandom);
            repeat ($urandom_range(1, 2500)) @(negedge i_clk);
        end
        while ($urandom_range(0, 99) < idle_pct) begin
            start   <= 1'b0;
            i_value <= FIELD_W'($urandom);
            @(negedge i_clk);
        end
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        queue_prime_powers(value);
    endtask

    task automatic run_random(input int items, input int idle_pct);
        repeat (items) send_request(pick_value(), idle_pct);
    endtask

    task automatic test_directed();
        logic [FIELD_W-1:0] corner_values [22] = '{
            16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd8, 16'd9, 16'd49, 16'd12,
            16'hFFFF, 16'd65521, 16'd32749, 16'd32768, 16'd30030, 16'd63001,
            16'd65025, 16'd59049, 16'd65534, 16'hAAAA, 16'h5555, 16'd1
        };
        foreach (corner_values[k]) send_request(corner_values[k], 0);
    endtask

    task automatic test_back_to_back();
        run_random(65, 0);
    endtask

    task automatic test_sender_idle();
        run_random(65, 77);
    endtask

    task automatic test_mixed_idle();
        run_random(65, 36);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_factors.size() == 0) begin
                report_mismatch($sformatf("unexpected result pp=%0d last=%0b empty=%0b",
                                          o_prime_power, o_last, o_empty_res));
            end else begin
                want = expected_factors.pop_front();
                if (o_prime_power !== want.prime_power)
                    report_mismatch($sformatf("value %0d: prime_power %0d, expected %0d",
                                              want.source, o_prime_power, want.prime_power));
                if (o_last !== want.last)
                    report_mismatch($sformatf("value %0d: last %0b, expected %0b",
                                              want.source, o_last, want.last));
                if (o_empty_res !== want.empty_res)
                    report_mismatch($sformatf("value %0d: empty_res %0b, expected %0b",
                                              want.source, o_empty_res, want.empty_res));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_value = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_back_to_back();
        test_sender_idle();
        test_mixed_idle();

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_factors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
